/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* sv/lbcr_pkg.sv */
// ----------------------------------------------------------------------------
// lbcr_pkg
// Constants, byte selects and controller/datapath link types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbcr_pkg;

	localparam int unsigned LCD_WIDTH  = 84;
	localparam int unsigned LCD_HEIGHT = 48;
	localparam int unsigned ROW_MOD    = LCD_HEIGHT / 9 + 1;

	localparam int unsigned COL_W     = 7;
	localparam int unsigned ROW_W     = 3;
	localparam int unsigned MAX_ROWS  = 6;

	// reciprocal wrap: quotient = (value * RECIP) >> RECIP_SH for 8-bit values
	localparam int unsigned RECIP_SH  = 16;
	localparam int unsigned PROD_W    = RECIP_SH + 8;
	localparam int unsigned COL_RECIP = ((1 << RECIP_SH) + LCD_WIDTH - 1) / LCD_WIDTH;
	localparam int unsigned ROW_RECIP = ((1 << RECIP_SH) + ROW_MOD - 1) / ROW_MOD;

	localparam logic [7:0] CMD_COL    = 8'h80;
	localparam logic [7:0] CMD_ROW    = 8'h40;
	localparam logic [7:0] DATA_FULL  = 8'hff;
	localparam logic [7:0] DATA_EMPTY = 8'h00;

	typedef enum logic [2:0] {
		SEL_RED_COL,
		SEL_CUR_COL,
		SEL_CUR_ROW,
		SEL_WALK_ROW,
		SEL_DATA,
		SEL_NEXT_COL
	} byte_sel_t;

	typedef struct packed {
		logic              load_cur;
		logic              load_bar;
		logic              reduce;
		logic              emit;
		byte_sel_t         sel;
		logic              last;
		logic              advance_row;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_row;
	} sts_t;

endpackage

/* sv/lbcr_if.sv */
// ----------------------------------------------------------------------------
// lbcr_if
// Valid/ready channels: request words, output byte words, configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbcr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] bar_value;
	logic [7:0] cursor_col;
	logic [7:0] cursor_row;

	modport source (output valid, req_type, bar_value, cursor_col, cursor_row, input ready);
	modport sink (input valid, req_type, bar_value, cursor_col, cursor_row, output ready);
endinterface

interface lbcr_rsp_if;
	logic       valid;
	logic       ready;
	logic       is_data;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, is_data, out_byte, last, input ready);
	modport sink (input valid, is_data, out_byte, last, output ready);
endinterface

interface lbcr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] bar_rows;

	modport source (output valid, bar_rows, input ready);
	modport sink (input valid, bar_rows, output ready);
endinterface

/* sv/lcd_bar_column_renderer_unit.sv */
// ----------------------------------------------------------------------------
// lcd_bar_column_renderer_unit
// Bar-graph column renderer emitting command and data bytes for a
// page-addressed monochrome LCD.
// ----------------------------------------------------------------------------
// Takes one request word at a time and streams one output byte word per
// cycle, while the output is not stalled, through a registered output stage.
// A set-cursor word passes the accept state, the column/row wrap step (two
// parallel reciprocal multiplies and subtracts), then the two cursor
// commands, before the next ready. A bar word passes the accept state and
// then emits its bytes (column, row, data for each page row, then the
// closing cursor pair). Output back-pressure stalls the sequence.
// The configuration channel is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd_bar_column_renderer_unit (
	input  logic        clk,
	input  logic        arst_n,
	lbcr_req_if.sink    req,
	lbcr_rsp_if.source  rsp,
	lbcr_cfg_if.sink    cfg
);

	lbcr_pkg::cmd_t cmd;
	lbcr_pkg::sts_t sts;

	lbcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd)
	);

	lbcr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.bar_value  (req.bar_value),
		.cursor_col (req.cursor_col),
		.cursor_row (req.cursor_row),
		.cfg        (cfg),
		.rsp        (rsp),
		.cmd        (cmd),
		.sts        (sts)
	);

	`ASSERT_IMPLIES(a_emit_free, clk, arst_n, cmd.emit, sts.out_free)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, req.valid && req.ready, !req.ready)
	`ASSERT_NEXT(a_last_idle, clk, arst_n, cmd.emit && cmd.last, req.ready && rsp.valid && rsp.last)

endmodule

/* sv/lbcr_ctrl.sv */
// ----------------------------------------------------------------------------
// lbcr_ctrl
// Sequencer: accepts request words, steps the wrap unit, orders byte output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbcr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	lbcr_req_if.sink        req,
	input  lbcr_pkg::sts_t  sts,
	output lbcr_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CUR_COL,
		ST_CUR_ROW,
		ST_BAR_COL,
		ST_BAR_ROW,
		ST_BAR_DATA,
		ST_END_COL
	} state_t;

	state_t                      state_q;
	logic                        accept;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		cmd             = '0;
		cmd.sel         = lbcr_pkg::SEL_CUR_COL;
		cmd.load_cur    = accept && req.req_type;
		cmd.load_bar    = accept && !req.req_type;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
			end
			ST_CUR_COL: begin
				cmd.emit = sts.out_free;
				cmd.sel  = lbcr_pkg::SEL_RED_COL;
			end
			ST_CUR_ROW: begin
				cmd.emit = sts.out_free;
				cmd.sel  = lbcr_pkg::SEL_CUR_ROW;
				cmd.last = 1'b1;
			end
			ST_BAR_COL: begin
				cmd.emit = sts.out_free;
				cmd.sel  = lbcr_pkg::SEL_CUR_COL;
			end
			ST_BAR_ROW: begin
				cmd.emit = sts.out_free;
				cmd.sel  = lbcr_pkg::SEL_WALK_ROW;
			end
			ST_BAR_DATA: begin
				cmd.emit        = sts.out_free;
				cmd.sel         = lbcr_pkg::SEL_DATA;
				cmd.advance_row = sts.out_free;
			end
			ST_END_COL: begin
				cmd.emit = sts.out_free;
				cmd.sel  = lbcr_pkg::SEL_NEXT_COL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= req.req_type ? ST_REDUCE : ST_BAR_COL;
					end
				end
				ST_REDUCE: begin
					state_q <= ST_CUR_COL;
				end
				ST_CUR_COL: begin
					if (sts.out_free) state_q <= ST_CUR_ROW;
				end
				ST_CUR_ROW: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_BAR_COL: begin
					if (sts.out_free) state_q <= ST_BAR_ROW;
				end
				ST_BAR_ROW: begin
					if (sts.out_free) state_q <= ST_BAR_DATA;
				end
				ST_BAR_DATA: begin
					if (sts.out_free) state_q <= sts.last_row ? ST_END_COL : ST_BAR_COL;
				end
				ST_END_COL: begin
					if (sts.out_free) state_q <= ST_CUR_ROW;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/lbcr_dp.sv */
// ----------------------------------------------------------------------------
// lbcr_dp
// Datapath: cursor state, wrap unit, bar row walk, output byte register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbcr_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      bar_value,
	input  logic [7:0]      cursor_col,
	input  logic [7:0]      cursor_row,
	lbcr_cfg_if.sink        cfg,
	lbcr_rsp_if.source      rsp,
	input  lbcr_pkg::cmd_t  cmd,
	output lbcr_pkg::sts_t  sts
);

	logic [2:0]                 bar_rows_q;
	logic [lbcr_pkg::COL_W-1:0] cur_col_q;
	logic [lbcr_pkg::ROW_W-1:0] cur_row_q;
	logic [lbcr_pkg::ROW_W-1:0] walk_row_q;
	logic [7:0]                 col_red_q;
	logic [7:0]                 row_red_q;
	logic [5:0]                 lvl_q;
	logic [5:0]                 base_q;

	logic                       rsp_valid_q;
	logic                       is_data_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;

	logic [2:0]                  rows_c;
	logic [5:0]                  rows8_c;
	logic [5:0]                  lvl_c;
	logic [lbcr_pkg::PROD_W-1:0] col_prod_c;
	logic [lbcr_pkg::PROD_W-1:0] row_prod_c;
	logic [7:0]                  col_quo_c;
	logic [7:0]                  row_quo_c;
	logic [7:0]                  col_sub_c;
	logic [7:0]                  row_sub_c;
	logic [lbcr_pkg::COL_W-1:0]  next_col_c;
	logic [lbcr_pkg::ROW_W-1:0]  next_row_c;
	logic [5:0]                  fill_c;
	logic [3:0]                  shamt_c;
	logic [7:0]                  data_c;
	logic [7:0]                  byte_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_rows_q <= 3'(lbcr_pkg::MAX_ROWS);
		end else if (cfg.valid && cfg.ready) begin
			bar_rows_q <= cfg.bar_rows;
		end
	end

	// clamp rows to 1..6 and the level to the bar height
	always_comb begin
		if (bar_rows_q == 3'd0)
			rows_c = 3'd1;
		else if (bar_rows_q > 3'(lbcr_pkg::MAX_ROWS))
			rows_c = 3'(lbcr_pkg::MAX_ROWS);
		else
			rows_c = bar_rows_q;
		rows8_c = {rows_c, 3'b000};
		lvl_c   = (bar_value > {2'b00, rows8_c}) ? rows8_c : bar_value[5:0];
	end

	// wrap by reciprocal multiply, then subtract quotient times modulus
	assign col_prod_c = lbcr_pkg::PROD_W'(col_red_q)
		* lbcr_pkg::PROD_W'(lbcr_pkg::COL_RECIP);
	assign row_prod_c = lbcr_pkg::PROD_W'(row_red_q)
		* lbcr_pkg::PROD_W'(lbcr_pkg::ROW_RECIP);
	assign col_quo_c  = col_prod_c[lbcr_pkg::PROD_W-1:lbcr_pkg::RECIP_SH];
	assign row_quo_c  = row_prod_c[lbcr_pkg::PROD_W-1:lbcr_pkg::RECIP_SH];
	assign col_sub_c  = col_quo_c * 8'(lbcr_pkg::LCD_WIDTH);
	assign row_sub_c  = row_quo_c * 8'(lbcr_pkg::ROW_MOD);

	assign next_col_c = (8'(cur_col_q) + 8'd1 == 8'(lbcr_pkg::LCD_WIDTH))
		? '0 : cur_col_q + 1'b1;
	assign next_row_c = (4'(walk_row_q) + 4'd1 == 4'(lbcr_pkg::ROW_MOD))
		? '0 : walk_row_q + 1'b1;

	// page fill: pixels of the level that fall in the current page row
	always_comb begin
		fill_c  = lvl_q - base_q;
		shamt_c = 4'd8 - fill_c[3:0];
		if (lvl_q <= base_q)
			data_c = lbcr_pkg::DATA_EMPTY;
		else if (fill_c >= 6'd8)
			data_c = lbcr_pkg::DATA_FULL;
		else
			data_c = 8'(lbcr_pkg::DATA_FULL << shamt_c);
	end

	always_comb begin
		unique case (cmd.sel)
			lbcr_pkg::SEL_RED_COL:  byte_c = lbcr_pkg::CMD_COL | {1'b0, col_red_q[6:0]};
			lbcr_pkg::SEL_CUR_COL:  byte_c = lbcr_pkg::CMD_COL | {1'b0, cur_col_q};
			lbcr_pkg::SEL_CUR_ROW:  byte_c = lbcr_pkg::CMD_ROW | {5'b0, cur_row_q};
			lbcr_pkg::SEL_WALK_ROW: byte_c = lbcr_pkg::CMD_ROW | {5'b0, walk_row_q};
			lbcr_pkg::SEL_DATA:     byte_c = data_c;
			lbcr_pkg::SEL_NEXT_COL: byte_c = lbcr_pkg::CMD_COL | {1'b0, next_col_c};
			default:                byte_c = lbcr_pkg::DATA_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (cmd.emit) begin
			if (cmd.sel == lbcr_pkg::SEL_RED_COL) begin
				cur_col_q <= col_red_q[6:0];
				cur_row_q <= row_red_q[2:0];
			end else if (cmd.sel == lbcr_pkg::SEL_NEXT_COL) begin
				cur_col_q <= next_col_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			col_red_q <= cursor_col;
			row_red_q <= cursor_row;
		end else if (cmd.reduce) begin
			col_red_q <= col_red_q - col_sub_c;
			row_red_q <= row_red_q - row_sub_c;
		end
		if (cmd.load_bar) begin
			lvl_q      <= lvl_c;
			base_q     <= rows8_c - 6'd8;
			walk_row_q <= cur_row_q;
		end else if (cmd.advance_row) begin
			base_q     <= base_q - 6'd8;
			walk_row_q <= next_row_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			is_data_q  <= (cmd.sel == lbcr_pkg::SEL_DATA);
			out_byte_q <= byte_c;
			last_q     <= cmd.last;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.is_data  = is_data_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.last     = last_q;

	assign sts.out_free = !rsp_valid_q || rsp.ready;
	assign sts.last_row = (base_q == 6'd0);

endmodule

/* tb/lcd_bar_column_renderer_unit_test.sv */
// ----------------------------------------------------------------------------
// lcd_bar_column_renderer_unit_test
// Self-checking bench for the bar-graph column renderer.
// ----------------------------------------------------------------------------
// Drives set-cursor and bar words into the request channel. Writes the
// bar_rows register between phases. A local model of the cursor and the bar
// fill predicts every command and data byte. Each byte word that the block
// emits is checked against the oldest prediction. Covered: directed bar
// shapes, column and row wrap, all bar_rows settings including the out-of-range
// ones, random traffic with stall bursts on both sides, and a long output
// hold-off that backs the block up into its request port.
`timescale 1ns / 1ps

module lcd_bar_column_renderer_unit_test;

	localparam logic REQ_BAR    = 1'b0;
	localparam logic REQ_CURSOR = 1'b1;
	localparam logic BYTE_CMD   = 1'b0;
	localparam logic BYTE_DATA  = 1'b1;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic       req_type;
		logic [7:0] bar_value;
		logic [7:0] cursor_col;
		logic [7:0] cursor_row;
	} req_word_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] out_byte;
		logic       last;
	} lcd_byte_t;

	logic clk;
	logic arst_n;

	lbcr_req_if req_ch ();
	lbcr_rsp_if rsp_ch ();
	lbcr_cfg_if cfg_ch ();

	lcd_bar_column_renderer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	lcd_byte_t  bytes_due[$];
	logic [6:0] pen_col;
	logic [2:0] pen_row;
	logic [2:0] rows_cfg;
	int         mismatches;
	int         cycles;
	bit         idle_en;
	int         hold_request;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic push_byte(logic is_data, logic [7:0] b);
		lcd_byte_t e;
		e.is_data = is_data;
		e.out_byte = b;
		e.last = 1'b0;
		bytes_due.push_back(e);
	endtask

	task automatic place_pen(int col, int row);
		pen_col = 7'(col % lbcr_pkg::LCD_WIDTH);
		pen_row = 3'(row % lbcr_pkg::ROW_MOD);
		push_byte(BYTE_CMD, lbcr_pkg::CMD_COL | 8'(pen_col));
		push_byte(BYTE_CMD, lbcr_pkg::CMD_ROW | 8'(pen_row));
	endtask

	task automatic render_request(req_word_t w);
		int rows;
		int fill_px;
		int mark;
		int k;
		int c;
		int r;
		logic [7:0] fill;
		if (w.req_type == REQ_CURSOR) begin
			place_pen(w.cursor_col, w.cursor_row);
		end else begin
			rows = (rows_cfg == 0) ? 1
				: (rows_cfg > lbcr_pkg::MAX_ROWS) ? lbcr_pkg::MAX_ROWS : rows_cfg;
			fill_px = (w.bar_value > rows * 8) ? rows * 8 : w.bar_value;
			mark = (fill_px == rows * 8) ? 0 : (rows * 8 - 1 - fill_px) / 8;
			k = rows * 8 - mark * 8 - fill_px;
			c = pen_col;
			r = pen_row;
			for (int i = 0; i < rows; i++) begin
				if (i < mark) begin
					fill = lbcr_pkg::DATA_EMPTY;
				end else if (i == mark) begin
					fill = (k >= 8) ? lbcr_pkg::DATA_EMPTY : lbcr_pkg::DATA_FULL << k;
				end else begin
					fill = lbcr_pkg::DATA_FULL;
				end
				place_pen(c, r + i);
				push_byte(BYTE_DATA, fill);
			end
			place_pen(c + 1, r);
		end
		bytes_due[bytes_due.size() - 1].last = 1'b1;
	endtask

	function automatic req_word_t rand_word();
		req_word_t w;
		w.req_type = ($urandom_range(0, 3) == 0) ? REQ_CURSOR : REQ_BAR;
		w.bar_value = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 50));
		w.cursor_col = 8'($urandom_range(0, 255));
		w.cursor_row = 8'($urandom_range(0, 255));
		return w;
	endfunction

	task automatic send_word(req_word_t w);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = w.req_type;
		req_ch.bar_value = w.bar_value;
		req_ch.cursor_col = w.cursor_col;
		req_ch.cursor_row = w.cursor_row;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		render_request(w);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic send_bar(int value);
		req_word_t w;
		w = rand_word();
		w.req_type = REQ_BAR;
		w.bar_value = 8'(value);
		send_word(w);
	endtask

	task automatic send_cursor(int col, int row);
		req_word_t w;
		w = rand_word();
		w.req_type = REQ_CURSOR;
		w.cursor_col = 8'(col);
		w.cursor_row = 8'(row);
		send_word(w);
	endtask

	task automatic wait_drained();
		while (bytes_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_rows(logic [2:0] value);
		wait_drained();
		cfg_ch.valid = 1'b1;
		cfg_ch.bar_rows = value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		rows_cfg = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic test_reset_state();
		req_word_t w;
		w.req_type = REQ_BAR;
		w.bar_value = 8'd0;
		w.cursor_col = 8'hff;
		w.cursor_row = 8'hff;
		send_word(w);
		send_bar(48);
	endtask

	task automatic test_bar_shapes();
		send_bar(255);
		send_bar(1);
		send_bar(7);
		send_bar(8);
		send_bar(9);
		send_bar(40);
		send_bar(47);
		send_bar(24);
	endtask

	task automatic test_cursor_wrap();
		send_cursor(255, 255);
		send_cursor(83, 5);
		send_bar(20);
		send_cursor(84, 6);
		send_cursor(0, 0);
		send_cursor(167, 11);
		send_bar(33);
	endtask

	task automatic test_row_settings();
		write_rows(3'd0);
		send_bar(255);
		send_bar(3);
		write_rows(3'd7);
		send_bar(50);
		write_rows(3'd1);
		send_bar(4);
	endtask

	task automatic test_random_phases();
		logic [2:0] phase_rows[5];
		phase_rows = '{3'd2, 3'd3, 3'd4, 3'd5, 3'($urandom_range(0, 7))};
		for (int p = 0; p < 5; p++) begin
			write_rows(phase_rows[p]);
			idle_en = (p != 1);
			repeat (40) send_word(rand_word());
		end
		wait_drained();
	endtask

	task automatic test_output_hold();
		idle_en = 1'b0;
		write_rows(3'd6);
		hold_request = 300;
		repeat (15) send_word(rand_word());
		wait_drained();
	endtask

	task automatic test_quiet_tail();
		idle_en = 1'b0;
		write_rows(3'($urandom_range(1, 6)));
		repeat (30) send_word(rand_word());
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready = 1'b0;
				stall_left = $urandom_range(0, 15);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_byte
		lcd_byte_t got;
		lcd_byte_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.is_data = rsp_ch.is_data;
			got.out_byte = rsp_ch.out_byte;
			got.last = rsp_ch.last;
			if (bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected word: is_data=%b byte=%h last=%b",
						got.is_data, got.out_byte, got.last);
			end else begin
				want = bytes_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"mismatch: expected is_data=%b byte=%h last=%b,",
							" got is_data=%b byte=%h last=%b"},
							want.is_data, want.out_byte, want.last,
							got.is_data, got.out_byte, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lcd_bar_column_renderer_unit_test failed");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		idle_en = 1'b0;
		hold_request = 0;
		pen_col = '0;
		pen_row = '0;
		rows_cfg = 3'd6;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BAR;
		req_ch.bar_value = '0;
		req_ch.cursor_col = '0;
		req_ch.cursor_row = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.bar_rows = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		idle_en = 1'b1;
		test_reset_state();
		test_bar_shapes();
		test_cursor_wrap();
		test_row_settings();
		test_random_phases();
		test_output_hold();
		test_quiet_tail();
		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && bytes_due.size() == 0) begin
			$display("lcd_bar_column_renderer_unit_test passed");
		end else begin
			$display("lcd_bar_column_renderer_unit_test failed");
		end
		$finish;
	end

endmodule
